/* hdl/rol_pkg.sv */
`timescale 1ns / 1ps

package rol_pkg;

    localparam int DEF_CAPACITY = 32;

    localparam int OPCODE_W = 3;
    localparam int ELEM_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_MOVE    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_QUERY   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_REVERSE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

endpackage

/* hdl/recency_ordered_id_list.sv */
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit identifiers held in a single
// memory with one read and one write port, walked by a small sequencer that
// shares one 32-bit comparator. A command is taken when start is high and
// busy is low; exactly one result beat follows, marked by done for a single
// cycle, and the receiver cannot stall it. Every command first scans for the
// element, stopping at the first match or at the end of the list. Remove and
// move to back then shift the tail one entry per cycle; reverse swaps pairs
// from both ends inward, reading the low and high entries and then writing
// each. Clear, append and query finish with the scan. The result beat is
// registered from the last step, and the next command may be issued in the
// cycle in which done is high.
module recency_ordered_id_list #(
    parameter int CAPACITY = rol_pkg::DEF_CAPACITY
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rol_pkg::OPCODE_W-1:0]   opcode,
    input  logic signed [rol_pkg::ELEM_W-1:0] element,
    output logic                           done,
    output logic                           found,
    output logic [rol_pkg::COUNT_W-1:0]    entry_count,
    output logic [rol_pkg::STATUS_W-1:0]   status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_RV_CHK = 6'b001000,
        S_RV_RHI = 6'b010000,
        S_RV_WLO = 6'b100000
    } state_t;

    // last step of a swap writes the high entry from the held low value
    logic rv_whi_reg, rv_whi_next;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] wptr_reg, wptr_next;
    logic             chk_reg, chk_next;
    logic             hit_reg, hit_next;
    logic [rol_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic [rol_pkg::ELEM_W-1:0]   val_reg, val_next;
    logic [rol_pkg::ELEM_W-1:0]   tmp_reg, tmp_next;

    logic                         done_reg;
    logic                         found_reg;
    logic [rol_pkg::COUNT_W-1:0]  count_reg;
    logic [rol_pkg::STATUS_W-1:0] status_reg;

    logic                         fin;
    logic [rol_pkg::STATUS_W-1:0] status_res;
    logic [CNT_W+rol_pkg::COUNT_W-1:0] count_ext;

    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [rol_pkg::ELEM_W-1:0] rd_data_reg;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [rol_pkg::ELEM_W-1:0] wr_data;
    logic                       match;

    logic [rol_pkg::ELEM_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // the one shared comparator
    assign match = (rd_data_reg == val_reg);

    always_comb
    begin
        state_next  = state_reg;
        rv_whi_next = 1'b0;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        wptr_next   = wptr_reg;
        chk_next    = chk_reg;
        hit_next    = hit_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        tmp_next    = tmp_reg;
        fin         = 1'b0;
        status_res  = rol_pkg::ST_OK;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = wptr_reg[IDX_W-1:0];
        wr_data     = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    val_next   = element;
                    idx_next   = '0;
                    chk_next   = 1'b0;
                    hit_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // read entry idx while comparing the one read last cycle
                rd_en = (idx_reg < fill_reg);
                if ((chk_reg && match) || (idx_reg >= fill_reg))
                begin
                    hit_next   = chk_reg && match;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        rol_pkg::OP_CLEAR:
                        begin
                            fill_next = '0;
                            fin       = 1'b1;
                        end
                        rol_pkg::OP_APPEND:
                        begin
                            fin = 1'b1;
                            if (fill_reg >= CAP_C)
                            begin
                                status_res = rol_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = fill_reg[IDX_W-1:0];
                                wr_data   = val_reg;
                                fill_next = fill_reg + ONE_C;
                            end
                        end
                        rol_pkg::OP_REMOVE, rol_pkg::OP_MOVE:
                        begin
                            if (!hit_next)
                            begin
                                status_res = rol_pkg::ST_NOTFOUND;
                                fin        = 1'b1;
                            end
                            else
                            begin
                                // idx already points one past the match
                                wptr_next  = idx_reg - ONE_C;
                                chk_next   = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        rol_pkg::OP_REVERSE:
                        begin
                            if (fill_reg < TWO_C)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                wptr_next  = fill_reg - ONE_C;
                                state_next = S_RV_CHK;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + ONE_C;
                    chk_next = 1'b1;
                end
            end

            S_SHIFT:
            begin
                // pull each tail entry one place toward the front
                if (chk_reg)
                begin
                    wr_en     = 1'b1;
                    wptr_next = wptr_reg + ONE_C;
                end
                if (idx_reg < fill_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + ONE_C;
                    chk_next = 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                    if (!chk_reg)
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                        if (op_reg == rol_pkg::OP_REMOVE)
                        begin
                            fill_next = fill_reg - ONE_C;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = wptr_reg[IDX_W-1:0];
                            wr_data = val_reg;
                        end
                    end
                end
            end

            S_RV_CHK:
            begin
                if (rv_whi_reg)
                begin
                    // finish the previous swap: high entry takes the old low
                    wr_en     = 1'b1;
                    wr_addr   = wptr_reg[IDX_W-1:0];
                    wr_data   = tmp_reg;
                    idx_next  = idx_reg + ONE_C;
                    wptr_next = wptr_reg - ONE_C;
                    rd_addr   = idx_next[IDX_W-1:0];
                    if (idx_next < wptr_next)
                    begin
                        rd_en      = 1'b1;
                        state_next = S_RV_RHI;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_RV_RHI;
                end
            end

            S_RV_RHI:
            begin
                rd_en      = 1'b1;
                rd_addr    = wptr_reg[IDX_W-1:0];
                tmp_next   = rd_data_reg;
                state_next = S_RV_WLO;
            end

            S_RV_WLO:
            begin
                wr_en       = 1'b1;
                wr_addr     = idx_reg[IDX_W-1:0];
                rv_whi_next = 1'b1;
                state_next  = S_RV_CHK;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_ext = {{rol_pkg::COUNT_W{1'b0}}, fill_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rv_whi_reg <= 1'b0;
            fill_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rv_whi_reg <= rv_whi_next;
            fill_reg   <= fill_next;
            done_reg   <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        wptr_reg <= wptr_next;
        chk_reg  <= chk_next;
        hit_reg  <= hit_next;
        op_reg   <= op_next;
        val_reg  <= val_next;
        tmp_reg  <= tmp_next;
        if (fin)
        begin
            found_reg  <= hit_next;
            count_reg  <= count_ext[rol_pkg::COUNT_W-1:0];
            status_reg <= status_res;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign entry_count = count_reg;
    assign status      = status_reg;

endmodule

/* hdl/rol_checker.sv */
`timescale 1ns / 1ps

module rol_checker #(
    parameter int CAPACITY = rol_pkg::DEF_CAPACITY
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          found,
    input logic [rol_pkg::COUNT_W-1:0]   entry_count,
    input logic [rol_pkg::STATUS_W-1:0]  status
);

    localparam logic [rol_pkg::COUNT_W-1:0] CAP_MOD = rol_pkg::COUNT_W'(CAPACITY % 64);

    // an accepted command always holds the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // a result beat follows work and leaves the block free
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result beat without preceding work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3))
        else $error("undefined status code");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == rol_pkg::ST_FULL) |-> (entry_count == CAP_MOD))
        else $error("full status with list not at capacity");

    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == rol_pkg::ST_NOTFOUND) |-> !found)
        else $error("not-found status with found set");

endmodule

bind recency_ordered_id_list rol_checker #(.CAPACITY(CAPACITY)) u_rol_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .found       (found),
    .entry_count (entry_count),
    .status      (status)
);
